>>> hw/rtl/scfp_pkg.sv
// types, constants and command table shared by the frame parser modules
`default_nettype none

package scfp_pkg;

    // byte codes
    localparam logic [7:0] START_RESET = 8'd126;
    localparam logic [7:0] NEWLINE     = 8'd10;
    localparam logic [7:0] OPEN_PAREN  = 8'd40;
    localparam logic [7:0] CLOSE_PAREN = 8'd41;
    localparam logic [7:0] DIGIT_ZERO  = 8'd48;
    localparam logic [7:0] DIGIT_NINE  = 8'd57;

    // saturation limit of the decimal value
    localparam logic [29:0] VALUE_MAX = 30'd999999999;

    // depth of the queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // classification of one received word
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_START = 2'd0;
    localparam kind_t KIND_CLOSE = 2'd1;
    localparam kind_t KIND_DATA  = 2'd2;

    // classified word as it travels through the queue
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       is_open;
        logic       is_close;
        logic       is_digit;
        logic [3:0] digit;
    } scfp_word_t;

    // three-character command codes, first character in the top byte
    localparam int CMD_TABLE_SIZE = 20;
    localparam logic [23:0] CMD_TABLE [CMD_TABLE_SIZE] = '{
        "LTS", "LTA", "LTB", "LTC", "GRO",
        "TMR", "DRN", "FLL", "FLT", "DRT",
        "LDA", "SVA", "RCV", "RST", "QOT",
        "TEC", "TIC", "TOC", "GED", "PUD"
    };

endpackage

`default_nettype wire

>>> hw/rtl/scfp_ifs.sv
// valid/ready channel interfaces of the frame parser
`default_nettype none

// received byte channel
interface scfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// frame result channel
interface scfp_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  command_index;
    logic [29:0] value;
    logic        value_updated;

    modport source (output valid, output command_index, output value, output value_updated,
                    input ready);
    modport sink (input valid, input command_index, input value, input value_updated,
                  output ready);
endinterface

// start symbol write channel
interface scfp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_symbol;

    modport source (output valid, output start_symbol, input ready);
    modport sink (input valid, input start_symbol, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/scfp_front.sv
// front part: start symbol register and classification of received words
`default_nettype none

module scfp_front
    import scfp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    scfp_byte_if.sink      rx,
    scfp_cfg_if.sink       cfg,
    input  logic           q_full,
    output logic           q_push,
    output scfp_word_t     q_word
);

    logic [7:0] start_symbol_reg;
    logic [7:0] start_symbol_next;
    logic [7:0] digit_offset;

    // configuration write, always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        start_symbol_next = start_symbol_reg;
        if (cfg.valid)
        begin
            start_symbol_next = cfg.start_symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_symbol_reg <= START_RESET;
        end
        else
        begin
            start_symbol_reg <= start_symbol_next;
        end
    end

    // accept a word whenever the queue has room
    assign rx.ready = !q_full;
    assign q_push   = rx.valid && !q_full;

    // classify: start test has priority over newline
    assign digit_offset = rx.rx_byte - DIGIT_ZERO;

    always_comb
    begin
        if (rx.rx_byte == start_symbol_reg)
        begin
            q_word.kind = KIND_START;
        end
        else if (rx.rx_byte == NEWLINE)
        begin
            q_word.kind = KIND_CLOSE;
        end
        else
        begin
            q_word.kind = KIND_DATA;
        end
        q_word.data     = rx.rx_byte;
        q_word.is_open  = (rx.rx_byte == OPEN_PAREN);
        q_word.is_close = (rx.rx_byte == CLOSE_PAREN);
        q_word.is_digit = (rx.rx_byte >= DIGIT_ZERO) && (rx.rx_byte <= DIGIT_NINE);
        q_word.digit    = digit_offset[3:0];
    end

endmodule

`default_nettype wire

>>> hw/rtl/scfp_queue.sv
// short queue of classified words between the front and back parts
`default_nettype none

module scfp_queue
    import scfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  scfp_word_t push_word,
    output logic       full,
    input  logic       pop,
    output scfp_word_t head_word,
    output logic       not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    scfp_word_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scfp_back.sv
// back part: frame state, parenthesis scan, command lookup and result register
`default_nettype none

module scfp_back
    import scfp_pkg::*;
#(
    parameter int NUM_COMMANDS = 20,
    parameter int SCAN_LENGTH  = 10,
    parameter int FRAME_LENGTH = 20
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  scfp_word_t     q_head,
    output logic           q_pop,
    scfp_result_if.source  result
);

    localparam int POS_W        = $clog2(FRAME_LENGTH + 1);
    localparam int LOOKUP_LIMIT = (NUM_COMMANDS < CMD_TABLE_SIZE) ? NUM_COMMANDS
                                                                   : CMD_TABLE_SIZE;
    localparam logic [4:0] NO_MATCH = (NUM_COMMANDS > 31) ? 5'd31 : 5'(NUM_COMMANDS);
    localparam logic [POS_W-1:0] POS_FRAME_END = POS_W'(FRAME_LENGTH);
    localparam logic [POS_W-1:0] POS_SCAN_END  = POS_W'(SCAN_LENGTH);
    localparam logic [POS_W-1:0] POS_PREFIX    = POS_W'(3);

    // frame state
    logic             in_frame_reg;
    logic             in_frame_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       prefix_reg [3];
    logic [7:0]       prefix_next [3];
    logic             paren_reg;
    logic             paren_next;
    logic [29:0]      acc_reg;
    logic [29:0]      acc_next;
    logic [29:0]      held_reg;
    logic [29:0]      held_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [4:0]       out_index_reg;
    logic [4:0]       out_index_next;
    logic [29:0]      out_value_reg;
    logic [29:0]      out_value_next;
    logic             out_upd_reg;
    logic             out_upd_next;

    logic             emit;
    logic             out_free;
    logic             paren_scan;
    logic [33:0]      acc_wide;
    logic [4:0]       match_index;

    assign out_free = !out_valid_reg || result.ready;
    assign emit     = q_not_empty && (q_head.kind == KIND_CLOSE) && in_frame_reg;
    assign q_pop    = q_not_empty && (!emit || out_free);

    // accumulator times ten plus digit, widened for the saturation test
    assign acc_wide = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + 34'(q_head.digit);

    // lowest matching command code
    always_comb
    begin
        match_index = NO_MATCH;
        for (int k = LOOKUP_LIMIT - 1; k >= 0; k--)
        begin
            if (CMD_TABLE[k] == {prefix_reg[0], prefix_reg[1], prefix_reg[2]})
            begin
                match_index = 5'(k);
            end
        end
    end

    // frame state update for the word at the head of the queue
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        prefix_next   = prefix_reg;
        paren_next    = paren_reg;
        acc_next      = acc_reg;
        held_next     = held_reg;
        paren_scan    = paren_reg;
        if (q_pop)
        begin
            case (q_head.kind)
                KIND_START:
                begin
                    in_frame_next = 1'b1;
                    pos_next      = '0;
                    prefix_next   = '{8'd0, 8'd0, 8'd0};
                    paren_next    = 1'b0;
                    acc_next      = '0;
                end
                KIND_CLOSE:
                begin
                    if (in_frame_reg)
                    begin
                        in_frame_next = 1'b0;
                        if (!paren_reg)
                        begin
                            held_next = acc_reg;
                        end
                    end
                end
                KIND_DATA:
                begin
                    if (in_frame_reg && (pos_reg < POS_FRAME_END))
                    begin
                        if (pos_reg < POS_PREFIX)
                        begin
                            prefix_next[pos_reg[1:0]] = q_head.data;
                        end
                        if (pos_reg < POS_SCAN_END)
                        begin
                            if (q_head.is_open && !paren_reg)
                            begin
                                paren_scan = 1'b1;
                            end
                            else if (q_head.is_close && paren_reg)
                            begin
                                paren_scan = 1'b0;
                            end
                            paren_next = paren_scan;
                            if (paren_scan && q_head.is_digit)
                            begin
                                acc_next = (acc_wide > 34'(VALUE_MAX)) ? VALUE_MAX
                                                                       : acc_wide[29:0];
                            end
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    in_frame_next = in_frame_reg;
                end
            endcase
        end
    end

    // result register with load on close
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_upd_next   = out_upd_reg;
        if (out_free)
        begin
            out_valid_next = q_pop && emit;
            if (q_pop && emit)
            begin
                out_index_next = match_index;
                out_value_next = paren_reg ? held_reg : acc_reg;
                out_upd_next   = !paren_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            prefix_reg    <= '{8'd0, 8'd0, 8'd0};
            paren_reg     <= 1'b0;
            acc_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            prefix_reg    <= prefix_next;
            paren_reg     <= paren_next;
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_upd_reg   <= out_upd_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.command_index = out_index_reg;
    assign result.value         = out_value_reg;
    assign result.value_updated = out_upd_reg;

endmodule

`default_nettype wire

>>> hw/rtl/serial_command_frame_parser_unit.sv
// Serial command frame parser, top level.
// Channel rx takes one received byte per word; result delivers one word per closed
// frame with the matched command index, the decimal value and its update flag.
// Channel cfg writes the start symbol (reset value 126); write it only while idle.
// The start symbol clears and opens a frame, a newline closes it, bytes beyond
// FRAME_LENGTH are dropped. Digits inside parentheses within the first SCAN_LENGTH
// frame bytes build the value, which is kept only when no parenthesis stays open.
// Throughput: one byte per cycle while results are taken; a two-word queue sits between
// the classifier and the frame engine, which retires one queued word per cycle.
// A closing newline is written into the queue and loads the result register once that
// register is free; its result is then offered on the result channel.
// When the result receiver stalls, the frame engine holds the closing word, the
// queue fills within two bytes and rx.ready drops; other bytes keep flowing until
// a close word meets a full result register.
// Reset clears the frame state, the held value, the queue and the result valid flag
// and restores the start symbol; the queue leaves reset empty, so rx.ready is high.
`default_nettype none

module serial_command_frame_parser_unit
    import scfp_pkg::*;
#(
    parameter int NUM_COMMANDS = 20,
    parameter int SCAN_LENGTH  = 10,
    parameter int FRAME_LENGTH = 20
)
(
    input  logic          clk,
    input  logic          rst_n,
    scfp_byte_if.sink     rx,
    scfp_result_if.source result,
    scfp_cfg_if.sink      cfg
);

    logic       q_full;
    logic       q_push;
    scfp_word_t q_push_word;
    logic       q_pop;
    scfp_word_t q_head;
    logic       q_not_empty;

    // classifier and start symbol register
    scfp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_word (q_push_word)
    );

    // decoupling queue
    scfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .full      (q_full),
        .pop       (q_pop),
        .head_word (q_head),
        .not_empty (q_not_empty)
    );

    // frame engine and result register
    scfp_back #(
        .NUM_COMMANDS (NUM_COMMANDS),
        .SCAN_LENGTH  (SCAN_LENGTH),
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/scfp_checker.sv
// port-level checks of the frame parser result channel, bound to the top level
`default_nettype none

module scfp_checker
    import scfp_pkg::*;
#(
    parameter int NUM_COMMANDS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [4:0]  command_index,
    input  logic [29:0] value,
    input  logic        value_updated
);

    localparam logic [4:0] NO_MATCH = (NUM_COMMANDS > 31) ? 5'd31 : 5'(NUM_COMMANDS);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word withdrawn while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(command_index) && $stable(value)
                                    && $stable(value_updated))
        else $error("result payload changed while stalled");

    // command index is a table entry or the no-match code
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> command_index <= NO_MATCH)
        else $error("command index out of range");

    // value never exceeds the saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> value <= VALUE_MAX)
        else $error("value above saturation limit");

endmodule

bind serial_command_frame_parser_unit scfp_checker #(
    .NUM_COMMANDS (NUM_COMMANDS)
) u_scfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .command_index (result.command_index),
    .value         (result.value),
    .value_updated (result.value_updated)
);

`default_nettype wire
